// File: src/pfsf_pkg.sv
// pfsf_pkg: shared types, register indexes and constants for the PCM frame to float block.
// Depends on nothing.
package pfsf_pkg;
   localparam int unsigned FRAME_W = 64;
   localparam int unsigned LANES = 2;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IS_FLOAT = 8'd0,
      REG_BITS_PER_SAMPLE = 8'd1,
      REG_CHANNEL_COUNT = 8'd2
   } reg_index_type;

   typedef struct packed {
      logic [63:0] frame_bytes;
      logic        silent;
      logic        last_frame;
   } req_type;

   typedef struct packed {
      logic [31:0] left_sample;
      logic [31:0] right_sample;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       is_float;
      logic [5:0] bits_per_sample;
      logic [3:0] channel_count;
   } cfg_type;

   // Scale exponents: 2^-15, 2^-23, 2^-31 as biased exponent offsets.
   localparam logic [7:0] EXP16 = 8'd127 - 8'd15;
   localparam logic [7:0] EXP24 = 8'd127 - 8'd23;
   localparam logic [7:0] EXP32 = 8'd127 - 8'd31;
endpackage

// File: src/pcm_frame_to_stereo_float.sv
// pcm_frame_to_stereo_float: top level; config registers, two decode lanes, merge stage.
// Depends on pfsf_pkg and pfsf_lane.
//
// Use: write the format registers over the csr_ channel (index 0 is_float,
// 1 bits_per_sample, 2 channel_count) while no item is in flight. Items enter
// on req_ with start high; busy is always low so one item is taken per clock.
// Two lanes decode the left and right words side by side; a merge stage then
// copies left to right for mono. Each result appears on rsp_ with rsp_valid
// high for exactly one cycle, after the item has passed the lane register and
// then the merge register. Throughput is one item per cycle, set by the lane pipeline.
// The receiver cannot stall; results are never held. Reset clears the
// valid pipeline and restores is_float=1, bits_per_sample=32, channel_count=2.
// Silent items give zero samples; last passes through unchanged.
// Integer decodes divide by a power of two and round to nearest even.
module pcm_frame_to_stereo_float (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  pfsf_pkg::req_type             req_item,
   output logic                          rsp_valid,
   output pfsf_pkg::rsp_type             rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pfsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfsf_pkg::CSR_DATA_W-1:0] csr_data
);
   import pfsf_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic [1:0]  valid_ff, valid_in;
   logic        last_ff;
   logic [63:0] shifted;
   logic [31:0] lane_word [LANES];
   logic [31:0] lane_out  [LANES];
   logic        stereo_ff;
   rsp_type     rsp_ff, rsp_in;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_IS_FLOAT:        cfg_in.is_float = csr_data[0];
            REG_BITS_PER_SAMPLE: cfg_in.bits_per_sample = csr_data[5:0];
            REG_CHANNEL_COUNT:   cfg_in.channel_count = csr_data[3:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // right word: byte offset of bits_per_sample/8, bytes beyond seven read zero
   assign shifted = req_item.frame_bytes >> {cfg_ff.bits_per_sample[5:3] & 3'd7, 3'b000};
   assign lane_word[0] = req_item.frame_bytes[31:0];
   assign lane_word[1] = shifted[31:0];

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      pfsf_lane u_lane (
         .clock  (clock),
         .enable (!req_item.silent),
         .word   (lane_word[g]),
         .cfg    (cfg_ff),
         .sample (lane_out[g])
      );
   end

   assign valid_in = {valid_ff[0], start && !busy};

   always_comb begin
      rsp_in.left_sample = lane_out[0];
      rsp_in.right_sample = stereo_ff ? lane_out[1] : lane_out[0];
      rsp_in.last = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{is_float: 1'b1, bits_per_sample: 6'd32, channel_count: 4'd2};
         valid_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         valid_ff <= valid_in;
      end
      last_ff <= req_item.last_frame;
      stereo_ff <= cfg_ff.channel_count >= 4'd2;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff[1];
   assign rsp_item = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 rsp_valid) else $error("result missing two cycles after start");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(valid_ff[0])) else $error("result without item");
   a_last: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 (rsp_item.last == $past(req_item.last_frame, 2)))
      else $error("last flag not carried");
endmodule

// File: src/pfsf_lane.sv
// pfsf_lane: one sample decode lane; integer to float with round to nearest even, or float words passed through.
// Depends on pfsf_pkg.
module pfsf_lane (
   input  logic                     clock,
   input  logic                     enable,
   input  logic [31:0]              word,
   input  pfsf_pkg::cfg_type        cfg,
   output logic [31:0]              sample
);
   import pfsf_pkg::*;

   logic [31:0] val;
   logic        neg;
   logic [31:0] mag;
   logic [4:0]  lz;
   logic        found;
   logic [31:0] norm;
   logic [7:0]  ebase;
   logic        ok;
   logic [23:0] mant;
   logic        rnd;
   logic [24:0] msum;
   logic [7:0]  expo;
   logic [31:0] result;
   logic [31:0] sample_ff;
   logic [31:0] sample_in;

   always_comb begin
      ok = 1'b1;
      ebase = EXP32;
      case (cfg.bits_per_sample)
         6'd16: begin
            val = {{16{word[15]}}, word[15:0]};
            ebase = EXP16;
         end
         6'd24: begin
            val = {{8{word[23]}}, word[23:0]};
            ebase = EXP24;
         end
         6'd32: val = word;
         default: begin
            val = '0;
            ok = 1'b0;
         end
      endcase
      neg = val[31];
      mag = neg ? (~val + 32'd1) : val;
      lz = '0;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (!found && mag[i]) begin
            found = 1'b1;
            lz = 5'(31 - i);
         end
      end
      norm = mag << lz;
      mant = norm[31:8];
      rnd = norm[7] && (norm[6:0] != '0 || norm[8]);
      msum = {1'b0, mant} + 25'(rnd);
      expo = ebase + 8'd31 - {3'd0, lz} + {7'd0, msum[24]};
      if (!ok || !found)
         result = '0;
      else
         result = {neg, expo, msum[24] ? msum[23:1] : msum[22:0]};
      sample_in = cfg.is_float ? word : result;
      if (!enable)
         sample_in = '0;
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample = sample_ff;
endmodule
